[sv/plid_pkg.sv]
// Package for the positional list block: sizes, opcodes and status codes.
// No dependencies; used by the interfaces and the top level.
package plid_pkg;

  localparam int Capacity = 64;
  localparam int AddrW    = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int PosW     = 7;
  localparam int LenW     = 7;
  localparam int DataW    = 32;
  // common width for position vs. count compares
  localparam int CmpW     = (CntW > PosW) ? CntW : PosW;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

[sv/plid_if.sv]
// Valid/ready channel interfaces for the positional list block.
// Depends on plid_pkg.
interface plid_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         opcode;
  logic [plid_pkg::PosW-1:0]          position;
  logic signed [plid_pkg::DataW-1:0]  value;

  modport source (output valid, opcode, position, value, input ready);
  modport sink   (input valid, opcode, position, value, output ready);
endinterface

interface plid_out_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         status;
  logic                               item_valid;
  logic signed [plid_pkg::DataW-1:0]  item_value;
  logic                               last;
  logic [plid_pkg::LenW-1:0]          length;

  modport source (output valid, status, item_valid, item_value, last, length, input ready);
  modport sink   (input valid, status, item_valid, item_value, last, length, output ready);
endinterface

[sv/positional_list_insert_delete.sv]
// Positional list: ordered list of signed words in one synchronous RAM.
// Usage:
//   in_i  : command words (insert at position, delete at position, dump).
//   out_o : result words. Insert and delete answer with one word carrying
//           status and the new length; dump sends one word per entry in
//           list order, last set on the final one (an empty list gives one
//           empty word with last set).
// Sequencing: one command at a time; ready high only while idle.
//   Insert at p: entries from p up move one slot up, one entry moved per cycle
//   through the RAM read/write pipeline, then the value is written (only the
//   write at the end). Delete at p: entries above p move one slot down, if any.
//   Dump: each entry is read from the RAM, then loaded into the output register
//   before the next is read. Rejected commands and an empty dump skip the RAM.
// Reset clears the length and the controller; RAM contents stay undefined
// but only entries below the length are ever read. No clearing pass.
// When the receiver stalls, the output register holds its word and the
// controller waits; nothing is dropped.
module positional_list_insert_delete (
  input  logic      clk_i,
  input  logic      rst_ni,
  plid_in_if.sink   in_i,
  plid_out_if.source out_o
);
  import plid_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SHIFT    = 6'b000010,
    S_PUT      = 6'b000100,
    S_RESP     = 6'b001000,
    S_DUMP_RD  = 6'b010000,
    S_DUMP_OUT = 6'b100000
  } state_e;

  state_e                   state_q, state_d;
  logic [1:0]               op_q, op_d;
  logic [AddrW-1:0]         pos_q, pos_d;
  logic signed [DataW-1:0]  val_q, val_d;
  logic [CntW-1:0]          count_q, count_d;
  logic [AddrW-1:0]         ptr_q, ptr_d;
  logic                     rd_more_q, rd_more_d;
  logic                     wr_pend_q, wr_pend_d;
  logic [AddrW-1:0]         wr_addr_q, wr_addr_d;
  status_e                  st_q, st_d;

  logic                     out_valid_q, out_valid_d;
  logic [1:0]               out_status_q;
  logic                     out_item_valid_q;
  logic signed [DataW-1:0]  out_item_value_q;
  logic                     out_last_q;
  logic [LenW-1:0]          out_length_q;

  logic                     out_load;
  status_e                  ld_status;
  logic                     ld_item_valid;
  logic signed [DataW-1:0]  ld_item_value;
  logic                     ld_last;

  logic signed [DataW-1:0]  mem [Capacity];
  logic signed [DataW-1:0]  rdata_q;
  logic                     mem_we, mem_re;
  logic [AddrW-1:0]         mem_wa, mem_ra;
  logic signed [DataW-1:0]  mem_wd;

  logic                     out_free;
  logic                     in_fire;
  logic [CmpW-1:0]          pos_ext, cnt_ext, ptr_ext;

  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire = in_i.valid && in_i.ready;
  assign pos_ext = CmpW'(in_i.position);
  assign cnt_ext = CmpW'(count_q);
  assign ptr_ext = CmpW'(ptr_q);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    pos_d     = pos_q;
    val_d     = val_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    rd_more_d = rd_more_q;
    wr_pend_d = 1'b0;
    wr_addr_d = wr_addr_q;
    st_d      = st_q;
    mem_we    = 1'b0;
    mem_wa    = wr_addr_q;
    mem_wd    = rdata_q;
    mem_re    = 1'b0;
    mem_ra    = ptr_q;
    out_load      = 1'b0;
    ld_status     = st_q;
    ld_item_valid = 1'b0;
    ld_item_value = '0;
    ld_last       = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d  = in_i.opcode;
          val_d = in_i.value;
          pos_d = AddrW'(in_i.position);
          st_d  = ST_DONE;
          case (in_i.opcode)
            OP_INSERT: begin
              if (pos_ext > cnt_ext) begin
                st_d    = ST_RANGE;
                state_d = S_RESP;
              end else if (count_q == CntW'(Capacity)) begin
                st_d    = ST_FULL;
                state_d = S_RESP;
              end else if (pos_ext == cnt_ext) begin
                state_d = S_PUT;
              end else begin
                ptr_d     = AddrW'(count_q - CntW'(1));
                rd_more_d = 1'b1;
                state_d   = S_SHIFT;
              end
            end
            OP_DELETE: begin
              if (pos_ext >= cnt_ext) begin
                st_d    = ST_RANGE;
                state_d = S_RESP;
              end else if (pos_ext + CmpW'(1) == cnt_ext) begin
                count_d = count_q - CntW'(1);
                state_d = S_RESP;
              end else begin
                ptr_d     = AddrW'(in_i.position) + AddrW'(1);
                rd_more_d = 1'b1;
                state_d   = S_SHIFT;
              end
            end
            OP_DUMP: begin
              if (count_q == '0) begin
                state_d = S_RESP;
              end else begin
                ptr_d   = '0;
                state_d = S_DUMP_RD;
              end
            end
            default: begin
              st_d    = ST_RANGE;
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_SHIFT: begin
        // read one entry ahead, write the previous read one slot over
        mem_we = wr_pend_q;
        if (rd_more_q) begin
          mem_re    = 1'b1;
          wr_pend_d = 1'b1;
          if (op_q == OP_INSERT) begin
            wr_addr_d = ptr_q + AddrW'(1);
            ptr_d     = ptr_q - AddrW'(1);
            rd_more_d = (ptr_q != pos_q);
          end else begin
            wr_addr_d = ptr_q - AddrW'(1);
            ptr_d     = ptr_q + AddrW'(1);
            rd_more_d = (ptr_ext + CmpW'(1) != cnt_ext);
          end
        end else if (op_q == OP_INSERT) begin
          state_d = S_PUT;
        end else begin
          count_d = count_q - CntW'(1);
          state_d = S_RESP;
        end
      end
      S_PUT: begin
        mem_we  = 1'b1;
        mem_wa  = pos_q;
        mem_wd  = val_q;
        count_d = count_q + CntW'(1);
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_DUMP_RD: begin
        mem_re  = 1'b1;
        state_d = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        if (out_free) begin
          out_load      = 1'b1;
          ld_status     = ST_DONE;
          ld_item_valid = 1'b1;
          ld_item_value = rdata_q;
          ld_last       = (ptr_ext + CmpW'(1) == cnt_ext);
          if (ld_last) begin
            state_d = S_IDLE;
          end else begin
            ptr_d   = ptr_q + AddrW'(1);
            state_d = S_DUMP_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_more_q   <= 1'b0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_more_q   <= rd_more_d;
      wr_pend_q   <= wr_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    pos_q     <= pos_d;
    val_q     <= val_d;
    ptr_q     <= ptr_d;
    wr_addr_q <= wr_addr_d;
    st_q      <= st_d;
    if (out_load) begin
      out_status_q     <= ld_status;
      out_item_valid_q <= ld_item_valid;
      out_item_value_q <= ld_item_value;
      out_last_q       <= ld_last;
      out_length_q     <= LenW'(CmpW'(count_q));
    end
  end

  // list storage, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_ra];
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.item_valid = out_item_valid_q;
  assign out_o.item_value = out_item_value_q;
  assign out_o.last       = out_last_q;
  assign out_o.length     = out_length_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(count_q) <= CmpW'(Capacity))
    else $error("list length beyond capacity");

  a_write_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> CmpW'(mem_wa) <= CmpW'(count_q))
    else $error("RAM write beyond list end");

  a_count_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP || state_q == S_DUMP_RD || state_q == S_DUMP_OUT)
      |=> $stable(count_q))
    else $error("length changed outside insert or delete");

  a_dump_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_valid_q) |-> out_status_q == ST_DONE)
    else $error("dump word with non-done status");
`endif

endmodule

[tb/sv/positional_list_insert_delete_tb.sv]
`timescale 1ns / 100ps
// Testbench for positional_list_insert_delete: a directed command table, then random
// phases that grow, shrink and fill the list, checked word by word against a queue model.
// Depends on plid_pkg, the channel interfaces in plid_if.sv and the top level.
module positional_list_insert_delete_tb;
  import plid_pkg::*;

  localparam int     RandCmds   = 250;
  localparam int     TailWait   = 2 * Capacity + 32;
  localparam longint CycleLimit = 4_000_000;
  localparam int     MaxPos     = (1 << PosW) - 1;

  // opcode with no meaning, answered as out of range
  localparam logic [1:0] OpUnused = 2'd3;

  // random phase flavors
  localparam int GrowPhase   = 0;
  localparam int ShrinkPhase = 1;
  localparam int MixPhase    = 2;

  typedef struct packed {
    status_e                 status;
    logic                    item_valid;
    logic signed [DataW-1:0] item_value;
    logic                    last;
    logic [LenW-1:0]         length;
  } list_word_t;

  typedef struct packed {
    logic [1:0]              op;
    logic [PosW-1:0]         pos;
    logic signed [DataW-1:0] val;
    logic                    typed;
    status_e                 st;
    logic [LenW-1:0]         len;
  } cmd_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  plid_in_if  cmd_if ();
  plid_out_if res_if ();

  positional_list_insert_delete u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  always #6 clk_i = ~clk_i;

  logic signed [DataW-1:0] shadow_list[$];
  list_word_t              step_words[$];
  list_word_t              pending_words[$];
  list_word_t              want;
  int                      err_cnt = 0;
  int                      stall_left = 0;
  longint                  cycle_cnt;
  bit                      quiet = 1'b0;

  // typed rows carry one expected word; the others go through the list model
  cmd_row_t dir_rows [20] = '{
    '{OP_DUMP,   7'd0,   32'sd0,         1'b1, ST_DONE,  7'd0},  // empty dump
    '{OP_DELETE, 7'd0,   32'sd0,         1'b1, ST_RANGE, 7'd0},
    '{OP_INSERT, 7'd1,   32'sd5,         1'b1, ST_RANGE, 7'd0},
    '{OP_INSERT, 7'd0,   32'sh7FFF_FFFF, 1'b1, ST_DONE,  7'd1},
    '{OP_INSERT, 7'd0,   32'sh8000_0000, 1'b1, ST_DONE,  7'd2},
    '{OP_INSERT, 7'd2,   -32'sd1,        1'b1, ST_DONE,  7'd3},
    '{OP_INSERT, 7'd1,   32'sd0,         1'b1, ST_DONE,  7'd4},
    '{OP_INSERT, 7'd127, 32'shAAAA_AAAA, 1'b1, ST_RANGE, 7'd4},
    '{OpUnused,  7'd127, 32'sh5555_5555, 1'b1, ST_RANGE, 7'd4},
    '{OP_INSERT, 7'd4,   32'sh5555_5555, 1'b1, ST_DONE,  7'd5},
    '{OP_DUMP,   7'd127, 32'sd0,         1'b0, ST_DONE,  7'd0},
    '{OP_DELETE, 7'd4,   32'sd0,         1'b1, ST_DONE,  7'd4},
    '{OP_DELETE, 7'd0,   32'sd0,         1'b1, ST_DONE,  7'd3},
    '{OP_DELETE, 7'd127, 32'sd0,         1'b1, ST_RANGE, 7'd3},
    '{OP_DELETE, 7'd3,   32'sd0,         1'b1, ST_RANGE, 7'd3},
    '{OP_INSERT, 7'd3,   32'shAAAA_AAAA, 1'b1, ST_DONE,  7'd4},
    '{OP_DUMP,   7'd0,   32'sd0,         1'b0, ST_DONE,  7'd0},
    '{OP_DELETE, 7'd1,   32'sd0,         1'b1, ST_DONE,  7'd3},
    '{OP_INSERT, 7'd64,  32'sd9,         1'b1, ST_RANGE, 7'd3},
    '{OP_DUMP,   7'd0,   32'sd0,         1'b0, ST_DONE,  7'd0}
  };

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(99, 0);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic signed [DataW-1:0] random_value();
    case ($urandom_range(19, 0))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  function automatic list_word_t make_word(status_e st, logic iv,
                                           logic signed [DataW-1:0] v, logic lst);
    list_word_t w;
    w.status     = st;
    w.item_valid = iv;
    w.item_value = v;
    w.last       = lst;
    w.length     = LenW'(shadow_list.size());
    return w;
  endfunction

  // updates the shadow list and leaves the words this command produces in step_words
  function automatic void apply_list_op(input logic [1:0] op, input logic [PosW-1:0] pos,
                                        input logic signed [DataW-1:0] val);
    int n;
    n = shadow_list.size();
    step_words.delete();
    case (op)
      OP_INSERT: begin
        // position test comes before the full test
        if (int'(pos) > n) begin
          step_words.push_back(make_word(ST_RANGE, 1'b0, '0, 1'b1));
        end else if (n >= Capacity) begin
          step_words.push_back(make_word(ST_FULL, 1'b0, '0, 1'b1));
        end else begin
          shadow_list.insert(int'(pos), val);
          step_words.push_back(make_word(ST_DONE, 1'b0, '0, 1'b1));
        end
      end
      OP_DELETE: begin
        if (int'(pos) >= n) begin
          step_words.push_back(make_word(ST_RANGE, 1'b0, '0, 1'b1));
        end else begin
          shadow_list.delete(int'(pos));
          step_words.push_back(make_word(ST_DONE, 1'b0, '0, 1'b1));
        end
      end
      OP_DUMP: begin
        if (n == 0) begin
          step_words.push_back(make_word(ST_DONE, 1'b0, '0, 1'b1));
        end else begin
          for (int i = 0; i < n; i++)
            step_words.push_back(make_word(ST_DONE, 1'b1, shadow_list[i], i == n - 1));
        end
      end
      default: begin
        step_words.push_back(make_word(ST_RANGE, 1'b0, '0, 1'b1));
      end
    endcase
  endfunction

  task automatic run_cmd(input logic [1:0] op, input logic [PosW-1:0] pos,
                         input logic signed [DataW-1:0] val, input logic typed,
                         input status_e st, input logic [LenW-1:0] len);
    int         gap;
    list_word_t w;
    gap = quiet ? 0 : idle_len();
    if (gap != 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid    <= 1'b1;
    cmd_if.opcode   <= op;
    cmd_if.position <= pos;
    cmd_if.value    <= val;
    do @(posedge clk_i); while (cmd_if.ready !== 1'b1);
    apply_list_op(op, pos, val);
    if (typed) begin
      w.status     = st;
      w.item_valid = 1'b0;
      w.item_value = '0;
      w.last       = 1'b1;
      w.length     = len;
      pending_words.push_back(w);
    end else begin
      foreach (step_words[i]) pending_words.push_back(step_words[i]);
    end
  endtask

  task automatic random_cmd(input int flavor);
    int                      r;
    int                      n;
    int                      ins_cut;
    int                      del_cut;
    logic [1:0]              op;
    logic [PosW-1:0]         pos;
    r       = $urandom_range(99, 0);
    n       = shadow_list.size();
    ins_cut = (flavor == GrowPhase) ? 60 : (flavor == ShrinkPhase) ? 20 : 40;
    del_cut = (flavor == GrowPhase) ? 80 : 75;
    if (r < ins_cut)      op = OP_INSERT;
    else if (r < del_cut) op = OP_DELETE;
    else if (r < 96)      op = OP_DUMP;
    else                  op = OpUnused;
    if ($urandom_range(4, 0) == 0)
      pos = PosW'($urandom_range(MaxPos, 0));
    else if (op == OP_DELETE && n > 0)
      pos = PosW'($urandom_range(n - 1, 0));
    else
      pos = PosW'($urandom_range(n, 0));
    run_cmd(op, pos, random_value(), 1'b0, ST_DONE, '0);
  endtask

  // sender holds off until every outstanding word is back
  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_words.size() != 0);
  endtask

  // receiver: random stalls unless the phase is quiet
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      res_if.ready <= 1'b0;
      stall_left--;
    end else begin
      res_if.ready <= 1'b1;
      if (!quiet && $urandom_range(5, 0) == 0) stall_left = idle_len();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_words.size() == 0) begin
        $error("status: unexpected word, nothing pending (status %0d length %0d)",
               res_if.status, res_if.length);
        err_cnt++;
      end else begin
        want = pending_words.pop_front();
        if (res_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_if.status);
          err_cnt++;
        end
        if (res_if.item_valid !== want.item_valid) begin
          $error("item_valid: expected %0d, got %0d", want.item_valid, res_if.item_valid);
          err_cnt++;
        end
        if (res_if.item_value !== want.item_value) begin
          $error("item_value: expected %0d, got %0d", want.item_value, res_if.item_value);
          err_cnt++;
        end
        if (res_if.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, res_if.last);
          err_cnt++;
        end
        if (res_if.length !== want.length) begin
          $error("length: expected %0d, got %0d", want.length, res_if.length);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $error("watchdog expired after %0d cycles", cycle_cnt);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int sent;
    int phase_len;
    int flavor;
    bit fill_done;
    cmd_if.valid    = 1'b0;
    cmd_if.opcode   = OP_INSERT;
    cmd_if.position = '0;
    cmd_if.value    = '0;
    rst_ni          = 1'b0;
    sent            = 0;
    fill_done       = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      run_cmd(dir_rows[i].op, dir_rows[i].pos, dir_rows[i].val, dir_rows[i].typed,
              dir_rows[i].st, dir_rows[i].len);

    while (sent < RandCmds) begin
      if (!fill_done && sent >= 60) begin
        // fill to capacity, then hit the full and past-the-end cases and dump it all
        wait_drained();
        quiet = ($urandom_range(1, 0) == 1);
        while (shadow_list.size() < Capacity) begin
          run_cmd(OP_INSERT, PosW'($urandom_range(shadow_list.size(), 0)), random_value(),
                  1'b0, ST_DONE, '0);
          sent++;
        end
        run_cmd(OP_INSERT, PosW'(Capacity), random_value(), 1'b0, ST_DONE, '0);
        run_cmd(OP_INSERT, PosW'($urandom_range(Capacity - 1, 0)), random_value(),
                1'b0, ST_DONE, '0);
        run_cmd(OP_INSERT, PosW'($urandom_range(MaxPos, Capacity + 1)), random_value(),
                1'b0, ST_DONE, '0);
        run_cmd(OP_DUMP, PosW'($urandom_range(MaxPos, 0)), random_value(), 1'b0,
                ST_DONE, '0);
        run_cmd(OP_DELETE, PosW'(Capacity), random_value(), 1'b0, ST_DONE, '0);
        sent += 5;
        fill_done = 1'b1;
      end
      phase_len = $urandom_range(40, 15);
      flavor    = $urandom_range(MixPhase, GrowPhase);
      quiet     = ($urandom_range(3, 0) == 0);
      for (int k = 0; k < phase_len && sent < RandCmds; k++) begin
        random_cmd(flavor);
        sent++;
      end
      if ($urandom_range(1, 0) == 1) wait_drained();
    end

    wait_drained();
    repeat (TailWait) @(posedge clk_i);
    if (pending_words.size() != 0) begin
      $error("length: %0d expected words never arrived", pending_words.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[positional_list_insert_delete.f]
sv/plid_pkg.sv
sv/plid_if.sv
sv/positional_list_insert_delete.sv
tb/sv/positional_list_insert_delete_tb.sv
